// ===== rtl/core/utwm_pkg.sv =====
// ----------------------------------------------------------------------------
// utwm_pkg
// Shared types, codes and constants of the UTF-8 text width measure unit.
// ----------------------------------------------------------------------------
package utwm_pkg;

	// Default glyph memory depth
	localparam int GLYPH_DEPTH_DEF = 1024;
	// Width table entries, fixed by the 8-bit code range
	localparam int WIDTH_ENTRIES   = 256;
	localparam int WIDTH_AW        = 8;

	// Input commands
	localparam logic [1:0] CMD_TEXT  = 2'd0;
	localparam logic [1:0] CMD_WIDTH = 2'd1;
	localparam logic [1:0] CMD_GLYPH = 2'd2;

	// Configuration register indexes
	localparam logic CFG_FONT_HEIGHT = 1'b0;
	localparam logic CFG_GLYPH_COUNT = 1'b1;

	localparam logic [15:0] QMARK   = 16'h003f;
	localparam logic [15:0] NEWLINE = 16'h000a;
	localparam logic [23:0] SAT24   = 24'hffffff;

	// Font height thresholds of the scale classes
	localparam logic [7:0] FONT_TALL = 8'd28;
	localparam logic [7:0] FONT_MID  = 8'd20;

	typedef struct packed {
		logic load_text;
		logic wr_width;
		logic wr_glyph;
		logic close_line;
		logic start_search;
		logic retry_qmark;
		logic probe;
		logic step;
		logic take_glyph;
		logic width_read;
		logic take_width;
		logic accumulate;
		logic finish;
	} utwm_cmd_t;

	typedef struct packed {
		logic emit_avail;
		logic emit_is_nl;
		logic last_pend;
		logic search_open;
		logic key_wide;
		logic probe_hit;
	} utwm_stat_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== rtl/core/utf8_text_width_measure_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_text_width_measure_unit
// UTF-8 string width measurement with glyph table and width table lookup.
// ----------------------------------------------------------------------------
// Text bytes (command 0) are decoded as 1-, 2- or 3-byte UTF-8; every
// codepoint is looked up by binary search in the sorted glyph memory and, on a
// miss, in the 256-entry width memory, and the widest newline-separated line
// comes out as one beat after the byte marked last. Table writes (commands 1
// and 2) can follow back to back. A text byte is accepted, then its decoded
// codepoints (up to three) are handled one after another, then the codepoint
// list is found empty. A newline only closes the line; any other codepoint
// starts a search, then runs search probes (each one registered glyph memory
// read and one compare), up to ceil(log2(n+1)) probes for n valid glyphs, then
// takes the glyph advance on a hit or reads the width table, and is then
// accumulated. A codepoint of 0x100 or more that misses is searched a second
// time as '?'. After the list of the byte marked last is found empty, the
// result is loaded into the output register in the next cycle, or later while
// that register still holds an unaccepted beat; the input stays stalled until
// then.
// Both tables are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module utf8_text_width_measure_unit #(
	parameter int GLYPH_DEPTH = utwm_pkg::GLYPH_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  text_byte,
	input  logic        last,
	input  logic [9:0]  table_index,
	input  logic [15:0] glyph_code,
	input  logic [15:0] glyph_advance,
	input  logic [7:0]  width_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] max_line_width
);
	import utwm_pkg::*;

	utwm_cmd_t  cmd;
	utwm_stat_t st;

	utwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.st        (st)
	);

	utwm_dp #(
		.GLYPH_DEPTH (GLYPH_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_byte      (text_byte),
		.last           (last),
		.table_index    (table_index),
		.glyph_code     (glyph_code),
		.glyph_advance  (glyph_advance),
		.width_value    (width_value),
		.cmd            (cmd),
		.st             (st),
		.max_line_width (max_line_width)
	);

endmodule

// ===== rtl/core/utwm_ram.sv =====
// ----------------------------------------------------------------------------
// utwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module utwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [utwm_pkg::addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [utwm_pkg::addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	import utwm_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/utwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// utwm_ctrl
// Sequencer: accepts beats, walks decoded codepoints through glyph search,
// width lookup and accumulation, and hands out the result.
// ----------------------------------------------------------------------------
module utwm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            command,
	output logic                  in_stall,
	input  logic                  out_stall,
	output logic                  out_valid,
	output utwm_pkg::utwm_cmd_t   cmd,
	input  utwm_pkg::utwm_stat_t  st
);
	import utwm_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_NEXT   = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_PROBE  = 3'd3;
	localparam logic [2:0] S_WREAD  = 3'd4;
	localparam logic [2:0] S_ACC    = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_text = (command == CMD_TEXT);
					cmd.wr_width  = (command == CMD_WIDTH);
					cmd.wr_glyph  = (command == CMD_GLYPH);
					if (command == CMD_TEXT) begin
						state_d = S_NEXT;
					end
				end
			end
			S_NEXT: begin
				priority if (st.emit_avail && st.emit_is_nl) begin
					cmd.close_line = 1'b1;
				end else if (st.emit_avail) begin
					cmd.start_search = 1'b1;
					state_d          = S_SEARCH;
				end else if (st.last_pend) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_SEARCH: begin
				// a wide codepoint that misses is searched again as '?'
				priority if (st.search_open) begin
					cmd.probe = 1'b1;
					state_d   = S_PROBE;
				end else if (st.key_wide) begin
					cmd.retry_qmark = 1'b1;
				end else begin
					cmd.width_read = 1'b1;
					state_d        = S_WREAD;
				end
			end
			S_PROBE: begin
				if (st.probe_hit) begin
					cmd.take_glyph = 1'b1;
					state_d        = S_ACC;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_SEARCH;
				end
			end
			S_WREAD: begin
				cmd.take_width = 1'b1;
				state_d        = S_ACC;
			end
			S_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = S_NEXT;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/utwm_dp.sv =====
// ----------------------------------------------------------------------------
// utwm_dp
// Datapath: configuration, UTF-8 decoder, codepoint list, binary search
// over the glyph memory, width table, line accumulation and result.
// ----------------------------------------------------------------------------
module utwm_dp #(
	parameter int GLYPH_DEPTH = utwm_pkg::GLYPH_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [10:0]           cfg_data,
	input  logic [7:0]            text_byte,
	input  logic                  last,
	input  logic [9:0]            table_index,
	input  logic [15:0]           glyph_code,
	input  logic [15:0]           glyph_advance,
	input  logic [7:0]            width_value,
	input  utwm_pkg::utwm_cmd_t   cmd,
	output utwm_pkg::utwm_stat_t  st,
	output logic [23:0]           max_line_width
);
	import utwm_pkg::*;

	localparam int AW = addr_bits(GLYPH_DEPTH);
	localparam int CW = $clog2(GLYPH_DEPTH + 1);

	localparam logic [1:0] PH_LEAD   = 2'd0;
	localparam logic [1:0] PH_CONT2  = 2'd1;
	localparam logic [1:0] PH_CONT3A = 2'd2;
	localparam logic [1:0] PH_CONT3B = 2'd3;

	logic [7:0]  font_height_q;
	logic [10:0] glyph_total_q;
	logic [1:0]  phase_q;
	logic [7:0]  lead_q;
	logic [7:0]  second_q;
	logic        last_q;
	logic [15:0] emit_cp_q [3];
	logic [1:0]  emit_cnt_q;
	logic [1:0]  emit_idx_q;
	logic [15:0] key_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [16:0] char_w_q;
	logic [23:0] line_q;
	logic [23:0] widest_q;
	logic [23:0] max_line_width_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_height_q <= '0;
			glyph_total_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FONT_HEIGHT: font_height_q <= cfg_data[7:0];
				CFG_GLYPH_COUNT: glyph_total_q <= cfg_data;
				default:         font_height_q <= font_height_q;
			endcase
		end
	end

	// ---------------- decoder ----------------
	logic        cont, is_ascii, is_lead2, is_lead3;
	logic        do_lead, seq_emit, load_lead, load_second;
	logic [1:0]  pre_cnt, tail_cnt, n_phase;
	logic [15:0] seq_cp;
	logic [15:0] new_cp [3];
	logic [1:0]  new_cnt;

	always_comb begin
		cont     = (text_byte[7:6] == 2'b10);
		is_ascii = !text_byte[7];
		is_lead2 = (text_byte[7:5] == 3'b110);
		is_lead3 = (text_byte[7:4] == 4'b1110);

		do_lead     = 1'b0;
		seq_emit    = 1'b0;
		seq_cp      = QMARK;
		load_lead   = 1'b0;
		load_second = 1'b0;
		pre_cnt     = 2'd0;
		n_phase     = PH_LEAD;

		unique case (phase_q)
			PH_CONT2: begin
				if (cont) begin
					seq_emit = 1'b1;
					seq_cp   = {5'b0, lead_q[4:0], text_byte[5:0]};
				end else begin
					pre_cnt = 2'd1;
					do_lead = 1'b1;
				end
			end
			PH_CONT3A: begin
				if (cont) begin
					load_second = 1'b1;
					n_phase     = PH_CONT3B;
				end else begin
					pre_cnt = 2'd1;
					do_lead = 1'b1;
				end
			end
			PH_CONT3B: begin
				if (cont) begin
					seq_emit = 1'b1;
					seq_cp   = {lead_q[3:0], second_q[5:0], text_byte[5:0]};
				end else begin
					// lead and second byte each count as '?'
					pre_cnt = 2'd2;
					do_lead = 1'b1;
				end
			end
			PH_LEAD: begin
				do_lead = 1'b1;
			end
			default: begin
				do_lead = 1'b1;
			end
		endcase

		if (do_lead) begin
			priority if (is_ascii) begin
				seq_emit = 1'b1;
				seq_cp   = {8'b0, text_byte};
			end else if (is_lead2) begin
				load_lead = 1'b1;
				n_phase   = PH_CONT2;
			end else if (is_lead3) begin
				load_lead = 1'b1;
				n_phase   = PH_CONT3A;
			end else begin
				seq_emit = 1'b1;
				seq_cp   = QMARK;
			end
		end

		// unfinished sequence at the end of the string
		tail_cnt = 2'd0;
		if (last) begin
			priority if (n_phase == PH_CONT3B) begin
				tail_cnt = 2'd2;
			end else if (n_phase != PH_LEAD) begin
				tail_cnt = 2'd1;
			end else begin
				tail_cnt = 2'd0;
			end
			n_phase = PH_LEAD;
		end

		// all list entries are '?' but the one decoded codepoint
		for (int i = 0; i < 3; i++) begin
			new_cp[i] = (seq_emit && (pre_cnt == 2'(i))) ? seq_cp : QMARK;
		end
		new_cnt = pre_cnt + {1'b0, seq_emit} + tail_cnt;
	end

	logic [15:0] cur_cp;

	always_comb begin
		unique case (emit_idx_q)
			2'd0:    cur_cp = emit_cp_q[0];
			2'd1:    cur_cp = emit_cp_q[1];
			2'd2:    cur_cp = emit_cp_q[2];
			default: cur_cp = QMARK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_text) begin
			for (int i = 0; i < 3; i++) begin
				emit_cp_q[i] <= new_cp[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEAD;
			lead_q     <= '0;
			second_q   <= '0;
			last_q     <= 1'b0;
			emit_cnt_q <= '0;
			emit_idx_q <= '0;
		end else begin
			if (cmd.load_text) begin
				phase_q    <= n_phase;
				last_q     <= last;
				emit_cnt_q <= new_cnt;
				emit_idx_q <= '0;
				if (load_lead) begin
					lead_q <= text_byte;
				end
				if (load_second) begin
					second_q <= text_byte;
				end
			end else if (cmd.close_line || cmd.accumulate) begin
				emit_idx_q <= emit_idx_q + 2'd1;
			end else if (cmd.finish) begin
				phase_q  <= PH_LEAD;
				lead_q   <= '0;
				second_q <= '0;
				last_q   <= 1'b0;
			end
		end
	end

	// ---------------- glyph search ----------------
	logic [CW-1:0] glyph_n, span, mid;
	logic [31:0]   glyph_rdata;
	logic [15:0]   probe_code, probe_adv;
	logic          glyph_we;

	assign glyph_n  = (32'(glyph_total_q) > 32'(GLYPH_DEPTH)) ? CW'(GLYPH_DEPTH)
	                                                          : CW'(glyph_total_q);
	assign span     = hi_q - lo_q - CW'(1);
	assign mid      = lo_q + (span >> 1);
	assign glyph_we = cmd.wr_glyph && (32'(table_index) < 32'(GLYPH_DEPTH));

	utwm_ram #(
		.WIDTH (32),
		.DEPTH (GLYPH_DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (AW'(table_index)),
		.wdata ({glyph_code, glyph_advance}),
		.re    (cmd.probe),
		.raddr (AW'(mid)),
		.rdata (glyph_rdata)
	);

	assign probe_code = glyph_rdata[31:16];
	assign probe_adv  = glyph_rdata[15:0];

	// hi_q is exclusive: the open range is [lo_q, hi_q)
	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			key_q <= cur_cp;
			lo_q  <= '0;
			hi_q  <= glyph_n;
		end else if (cmd.retry_qmark) begin
			key_q <= QMARK;
			lo_q  <= '0;
			hi_q  <= glyph_n;
		end else if (cmd.step) begin
			if (key_q < probe_code) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
	end

	// ---------------- widths ----------------
	logic [7:0]  width_rdata;
	logic [18:0] adv_x5;
	logic [16:0] scaled;

	utwm_ram #(
		.WIDTH (8),
		.DEPTH (WIDTH_ENTRIES)
	) u_width_ram (
		.clk   (clk),
		.we    (cmd.wr_width && (table_index[9:WIDTH_AW] == '0)),
		.waddr (table_index[WIDTH_AW-1:0]),
		.wdata (width_value),
		.re    (cmd.width_read),
		.raddr (key_q[WIDTH_AW-1:0]),
		.rdata (width_rdata)
	);

	// 24/12, 15/12 = 5/4 or 12/12, never below one pixel
	always_comb begin
		adv_x5 = {3'b0, probe_adv} + {1'b0, probe_adv, 2'b0};
		priority if (font_height_q >= FONT_TALL) begin
			scaled = {probe_adv, 1'b0};
		end else if (font_height_q >= FONT_MID) begin
			scaled = adv_x5[18:2];
		end else begin
			scaled = {1'b0, probe_adv};
		end
		if (scaled == '0) begin
			scaled = 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_glyph) begin
			char_w_q <= scaled;
		end else if (cmd.take_width) begin
			char_w_q <= {9'b0, width_rdata};
		end
	end

	// ---------------- line accumulation ----------------
	logic [24:0] line_sum;
	logic [23:0] line_max;

	assign line_sum = {1'b0, line_q} + {8'b0, char_w_q};
	assign line_max = (line_q > widest_q) ? line_q : widest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= '0;
			widest_q <= '0;
		end else if (cmd.accumulate) begin
			line_q <= line_sum[24] ? SAT24 : line_sum[23:0];
		end else if (cmd.close_line) begin
			widest_q <= line_max;
			line_q   <= '0;
		end else if (cmd.finish) begin
			widest_q <= '0;
			line_q   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			max_line_width_q <= line_max;
		end
	end

	assign max_line_width = max_line_width_q;

	assign st.emit_avail  = (emit_idx_q < emit_cnt_q);
	assign st.emit_is_nl  = (cur_cp == NEWLINE);
	assign st.last_pend   = last_q;
	assign st.search_open = (lo_q < hi_q);
	assign st.key_wide    = (key_q[15:8] != '0);
	assign st.probe_hit   = (probe_code == key_q);

endmodule

// ===== rtl/core/utwm_checker.sv =====
// ----------------------------------------------------------------------------
// utwm_checker
// Port-level checks of the UTF-8 text width measure unit, bound to the top.
// ----------------------------------------------------------------------------
module utwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [23:0] max_line_width
);
	import utwm_pkg::*;

	// a text beat always starts work, so the next beat waits
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_TEXT) |=> in_stall)
		else $error("text beat did not start a busy period");

	// table writes and unknown commands finish at once
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command != CMD_TEXT) |=> !in_stall)
		else $error("non-text beat left the input stalled");

	// a result only appears at the end of a busy period
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without preceding work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(max_line_width))
		else $error("stalled result changed");

endmodule

bind utf8_text_width_measure_unit utwm_checker u_utwm_checker (.*);
